// ===== hw/rtl/motion_zone_hit_detector_defines.svh =====
// Assertion macros for the motion zone hit detector.
// Expects clk and rst_n in the scope of each use; defining NO_ASSERTIONS removes them.
`ifndef MOTION_ZONE_HIT_DETECTOR_DEFINES_SVH
`define MOTION_ZONE_HIT_DETECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define MZD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition implies another in the next cycle.
`define MZD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MZD_ASSERT(lbl, prop, msg)
`define MZD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mzd_pkg.sv =====
// Shared types and constants of the motion zone hit detector.
// No dependencies; the RTL modules of the block use it, mzd_stream_if does not.
package mzd_pkg;

    localparam int ZONES_DEF    = 8;
    localparam int RPZ_DEF      = 4;
    localparam int GRID_MAX     = 64;
    localparam int MASK_W       = 8;
    localparam int CNT_W        = 4;
    localparam int ZIDX_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    typedef enum logic [1:0] {
        REQ_RECT = 2'd0,
        REQ_CELL = 2'd1,
        REQ_EOF  = 2'd2
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_ZONES = 3'd0,
        CFG_ALERT_MASK   = 3'd1,
        CFG_RECT_COUNTS  = 3'd2,
        CFG_GRID_WIDTH   = 3'd3,
        CFG_GRID_HEIGHT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [2:0]        zone_index;
        logic [1:0]        rect_index;
        logic signed [7:0] rect_x;
        logic signed [7:0] rect_y;
        logic [7:0]        rect_w;
        logic [7:0]        rect_h;
        logic [5:0]        cell_x;
        logic [5:0]        cell_y;
        logic              cell_motion;
    } req_t;

    typedef struct packed {
        logic [MASK_W-1:0] hit_mask;
        logic [CNT_W-1:0]  hit_count;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

    typedef struct packed {
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic [7:0]        w;
        logic [7:0]        h;
    } rect_t;

    typedef struct packed {
        logic [3:0]  active_zones;
        logic [7:0]  alert_mask;
        logic [23:0] rect_counts;
        logic [6:0]  grid_width;
        logic [6:0]  grid_height;
    } cfg_state_t;

endpackage

// ===== hw/rtl/mzd_stream_if.sv =====
// Valid/ready channel used for requests, results and configuration writes.
// Payload type is a parameter; payload structs come from mzd_pkg.
interface mzd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/motion_zone_hit_detector.sv =====
// Motion zone hit detector. A motion cell that lies inside the grid and
// carries motion starts a scan over min(ZONES,8) * RECTS_PER_ZONE table
// entries; no new request is taken until the scan ends. The scan walks
// the rectangle table through its single read port, one rectangle per
// cycle, so that port sets the cell rate. End of frame waits while the
// result register stalls. No clearing pass follows reset: the user must
// write table entries before use; the block itself does not enforce it.
`include "motion_zone_hit_detector_defines.svh"

module motion_zone_hit_detector #(
    parameter int ZONES          = mzd_pkg::ZONES_DEF,
    parameter int RECTS_PER_ZONE = mzd_pkg::RPZ_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mzd_stream_if.sink   req,
    mzd_stream_if.source rsp,
    mzd_stream_if.sink   cfg
);

    localparam int DEPTH   = ZONES * RECTS_PER_ZONE;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW      = (RECTS_PER_ZONE > 1) ? $clog2(RECTS_PER_ZONE) : 1;
    localparam int NZ_SCAN = (ZONES < mzd_pkg::MASK_W) ? ZONES : mzd_pkg::MASK_W;
    localparam int WAW     = AW + 4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    mzd_pkg::cfg_state_t cfg_state;

    // Scan counters and latched cell position
    logic [AW-1:0]                 addr_reg, addr_next;
    logic [mzd_pkg::ZIDX_W-1:0]    zone_reg, zone_next;
    logic [SW-1:0]                 slot_reg, slot_next;
    logic [5:0]                    cx_reg, cx_next;
    logic [5:0]                    cy_reg, cy_next;

    // Tags of the rectangle in flight through the memory read
    logic                          rd_valid_reg;
    logic [mzd_pkg::ZIDX_W-1:0]    rd_zone_reg;
    logic [SW-1:0]                 rd_slot_reg;

    logic [mzd_pkg::MASK_W-1:0]    acc_reg, acc_next;
    logic [mzd_pkg::MASK_W-1:0]    hit_vec;

    logic                          out_valid_reg, out_valid_next;
    logic [mzd_pkg::MASK_W-1:0]    out_mask_reg, out_mask_next;
    logic [mzd_pkg::CNT_W-1:0]     out_count_reg, out_count_next;
    logic [mzd_pkg::CNT_W-1:0]     acc_count;

    logic                          req_xfer;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    logic [WAW-1:0]                wr_addr_wide;
    mzd_pkg::rect_t                mem_wr_data;
    logic                          mem_rd_en;
    mzd_pkg::rect_t                mem_rd_data;
    logic                          scan_last;
    logic                          cell_hit_grid;
    logic [8:0]                    lim_w;
    logic [8:0]                    lim_h;
    logic                          out_free;

    mzd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;

    // Rectangle write: drop writes to a zone or slot beyond the table
    assign wr_addr_wide = WAW'(req.data.zone_index) * WAW'(RECTS_PER_ZONE)
                          + WAW'(req.data.rect_index);
    assign mem_wr_addr  = wr_addr_wide[AW-1:0];
    assign mem_wr_en    = req_xfer && (req.data.req_type == mzd_pkg::REQ_RECT)
                          && ({3'b000, req.data.zone_index} < 6'(ZONES))
                          && ({2'b00, req.data.rect_index} < 4'(RECTS_PER_ZONE));
    assign mem_wr_data.x = req.data.rect_x;
    assign mem_wr_data.y = req.data.rect_y;
    assign mem_wr_data.w = req.data.rect_w;
    assign mem_wr_data.h = req.data.rect_h;

    assign mem_rd_en = (state_reg == ST_SCAN);

    mzd_rect_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data)
    );

    mzd_match #(
        .RECTS_PER_ZONE (RECTS_PER_ZONE),
        .SW             (SW)
    ) u_match (
        .rd_valid  (rd_valid_reg),
        .rect      (mem_rd_data),
        .zone      (rd_zone_reg),
        .slot      (rd_slot_reg),
        .cell_x    (cx_reg),
        .cell_y    (cy_reg),
        .cfg_state (cfg_state),
        .hit_vec   (hit_vec)
    );

    // Grid limits saturate at the largest supported grid
    assign lim_w = ({2'b00, cfg_state.grid_width} > 9'(mzd_pkg::GRID_MAX))
                   ? 9'(mzd_pkg::GRID_MAX) : {2'b00, cfg_state.grid_width};
    assign lim_h = ({2'b00, cfg_state.grid_height} > 9'(mzd_pkg::GRID_MAX))
                   ? 9'(mzd_pkg::GRID_MAX) : {2'b00, cfg_state.grid_height};
    assign cell_hit_grid = req.data.cell_motion
                           && ({3'b000, req.data.cell_x} < lim_w)
                           && ({3'b000, req.data.cell_y} < lim_h);

    assign scan_last = (zone_reg == mzd_pkg::ZIDX_W'(NZ_SCAN - 1))
                       && (slot_reg == SW'(RECTS_PER_ZONE - 1));

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        acc_count = '0;
        for (int i = 0; i < mzd_pkg::MASK_W; i++)
        begin
            acc_count = acc_count + mzd_pkg::CNT_W'(acc_reg[i]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        zone_next      = zone_reg;
        slot_next      = slot_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        acc_next       = acc_reg | hit_vec;
        out_valid_next = out_valid_reg;
        out_mask_next  = out_mask_reg;
        out_count_next = out_count_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if ((req.data.req_type == mzd_pkg::REQ_CELL) && cell_hit_grid)
                    begin
                        // Start a table walk from the first slot of zone zero
                        cx_next    = req.data.cell_x;
                        cy_next    = req.data.cell_y;
                        addr_next  = '0;
                        zone_next  = '0;
                        slot_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (req.data.req_type == mzd_pkg::REQ_EOF)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + AW'(1);
                if (slot_reg == SW'(RECTS_PER_ZONE - 1))
                begin
                    slot_next = '0;
                    zone_next = zone_reg + mzd_pkg::ZIDX_W'(1);
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                end
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // Hold the frame result until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mask_next  = acc_reg;
                    out_count_next = acc_count;
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= mem_rd_en;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        zone_reg      <= zone_next;
        slot_reg      <= slot_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        rd_zone_reg   <= zone_reg;
        rd_slot_reg   <= slot_reg;
        out_mask_reg  <= out_mask_next;
        out_count_reg <= out_count_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.data.hit_mask  = out_mask_reg;
    assign rsp.data.hit_count = out_count_reg;

    // A compare still in flight must never meet the mask transfer and clear
    `MZD_ASSERT(a_no_compare_in_emit, rd_valid_reg |-> (state_reg != ST_EMIT), "compare during emit")
    // Every table read issued during a scan comes back for compare
    `MZD_ASSERT_NEXT(a_scan_reads_back, state_reg == ST_SCAN, rd_valid_reg, "scan read lost")
    // Loading the result clears the frame mask
    `MZD_ASSERT_NEXT(a_emit_clears, (state_reg == ST_EMIT) && out_free, (acc_reg == '0) && out_valid_reg, "mask not cleared on emit")
    // The result count agrees with its mask
    `MZD_ASSERT(a_count_matches, out_valid_reg |-> (out_count_reg == 4'($countones(out_mask_reg))), "hit count mismatch")

endmodule

// ===== hw/rtl/mzd_cfg_regs.sv =====
// Configuration register file of the motion zone hit detector.
// Depends on mzd_pkg and mzd_stream_if.
module mzd_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    mzd_stream_if.sink          cfg,
    output mzd_pkg::cfg_state_t cfg_state
);

    mzd_pkg::cfg_state_t cfg_reg;
    mzd_pkg::cfg_state_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_state = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.data.reg_index)
                mzd_pkg::CFG_ACTIVE_ZONES: cfg_next.active_zones = cfg.data.wdata[3:0];
                mzd_pkg::CFG_ALERT_MASK:   cfg_next.alert_mask   = cfg.data.wdata[7:0];
                mzd_pkg::CFG_RECT_COUNTS:  cfg_next.rect_counts  = cfg.data.wdata[23:0];
                mzd_pkg::CFG_GRID_WIDTH:   cfg_next.grid_width   = cfg.data.wdata[6:0];
                mzd_pkg::CFG_GRID_HEIGHT:  cfg_next.grid_height  = cfg.data.wdata[6:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_zones <= 4'd0;
            cfg_reg.alert_mask   <= 8'd0;
            cfg_reg.rect_counts  <= 24'd0;
            cfg_reg.grid_width   <= 7'd32;
            cfg_reg.grid_height  <= 7'd24;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/mzd_rect_mem.sv =====
// Rectangle table: one write port, one read port with a registered read.
// Depends on mzd_pkg for the entry layout.
module mzd_rect_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  mzd_pkg::rect_t wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output mzd_pkg::rect_t rd_data
);

    mzd_pkg::rect_t rect_mem [DEPTH];
    mzd_pkg::rect_t rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rect_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= rect_mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/mzd_match.sv =====
// Coverage test of one stored rectangle against the current motion cell.
// Depends on mzd_pkg; yields a one-hot zone hit or zero.
module mzd_match #(
    parameter int RECTS_PER_ZONE = 4,
    parameter int SW             = 2
) (
    input  logic                          rd_valid,
    input  mzd_pkg::rect_t                rect,
    input  logic [mzd_pkg::ZIDX_W-1:0]    zone,
    input  logic [SW-1:0]                 slot,
    input  logic [5:0]                    cell_x,
    input  logic [5:0]                    cell_y,
    input  mzd_pkg::cfg_state_t           cfg_state,
    output logic [mzd_pkg::MASK_W-1:0]    hit_vec
);

    logic signed [9:0] cx;
    logic signed [9:0] cy;
    logic signed [9:0] x0;
    logic signed [9:0] y0;
    logic signed [9:0] x1;
    logic signed [9:0] y1;
    logic [2:0]        zone_rects;
    logic [3:0]        zone_lim;
    logic              in_rect;
    logic              zone_on;

    assign cx = signed'({4'b0000, cell_x});
    assign cy = signed'({4'b0000, cell_y});
    assign x0 = 10'(rect.x);
    assign y0 = 10'(rect.y);
    assign x1 = x0 + signed'({2'b00, rect.w});
    assign y1 = y0 + signed'({2'b00, rect.h});

    assign in_rect = (cx >= x0) && (cx < x1) && (cy >= y0) && (cy < y1);

    // Slots at or past the zone's count (saturated at the table row size) are unused.
    assign zone_rects = cfg_state.rect_counts[3*zone +: 3];
    assign zone_lim   = ({1'b0, zone_rects} > 4'(RECTS_PER_ZONE))
                        ? 4'(RECTS_PER_ZONE) : {1'b0, zone_rects};
    assign zone_on    = ({1'b0, zone} < cfg_state.active_zones)
                        && cfg_state.alert_mask[zone]
                        && (4'(slot) < zone_lim);

    always_comb
    begin
        hit_vec = '0;
        if (rd_valid && zone_on && in_rect)
        begin
            hit_vec[zone] = 1'b1;
        end
    end

endmodule
